[src/lsod_pkg.sv]
// Package for the laser sector obstacle detector.
// Register codes, field widths, reset values and shared types.
// No dependencies.
package lsod_pkg;

    localparam int MAX_RAYS_DEF = 1024;

    localparam int RANGE_W = 16;
    localparam int FRAC_W  = 8;
    localparam int BOUND_W = 11;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int NUM_SEC = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_NEAR_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_COUNT_FRACTION = 3'd1;
    localparam logic [IDX_W-1:0] REG_RIGHT_START    = 3'd2;
    localparam logic [IDX_W-1:0] REG_RIGHT_END      = 3'd3;
    localparam logic [IDX_W-1:0] REG_FRONT_START    = 3'd4;
    localparam logic [IDX_W-1:0] REG_FRONT_END      = 3'd5;
    localparam logic [IDX_W-1:0] REG_LEFT_START     = 3'd6;
    localparam logic [IDX_W-1:0] REG_LEFT_END       = 3'd7;

    // reset values: every sector uncovered
    localparam logic [RANGE_W-1:0] NEAR_RST  = 16'd0;
    localparam logic [FRAC_W-1:0]  FRAC_RST  = 8'd128;
    localparam logic [BOUND_W-1:0] START_RST = 11'd1;
    localparam logic [BOUND_W-1:0] END_RST   = 11'd0;

    // sector index in the flag vector
    localparam int SEC_RIGHT = 0;
    localparam int SEC_FRONT = 1;
    localparam int SEC_LEFT  = 2;

    // per-word control handed to each sector unit
    typedef struct packed {
        logic step;   // word in the input register is consumed this cycle
        logic hit;    // valid, near and inside the scan
        logic last;   // final ray of the scan
    } t_sec_ctl;

endpackage

[src/lsod_if.sv]
// Handshake channels of the laser sector obstacle detector.
// Depends on lsod_pkg for field widths.
interface lsod_in_if;
    logic                          valid;
    logic                          ready;
    logic [lsod_pkg::RANGE_W-1:0]  sample_range;
    logic                          sample_valid;
    logic                          scan_last;

    modport source (output valid, sample_range, sample_valid, scan_last, input ready);
    modport sink   (input valid, sample_range, sample_valid, scan_last, output ready);
endinterface

interface lsod_out_if;
    logic valid;
    logic ready;
    logic obstacle_right;
    logic obstacle_front;
    logic obstacle_left;

    modport source (output valid, obstacle_right, obstacle_front, obstacle_left, input ready);
    modport sink   (input valid, obstacle_right, obstacle_front, obstacle_left, output ready);
endinterface

[src/lsod_sector.sv]
// One angular sector: near-ray counter and obstacle flag.
// Depends on lsod_pkg.
module lsod_sector #(
    parameter int MAX_RAYS = lsod_pkg::MAX_RAYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsod_pkg::t_sec_ctl            i_ctl,
    input  logic [$clog2(MAX_RAYS+1)-1:0] i_ray_idx,
    input  logic [lsod_pkg::BOUND_W-1:0]  i_start,
    input  logic [lsod_pkg::BOUND_W-1:0]  i_end,
    input  logic [lsod_pkg::FRAC_W-1:0]   i_frac,
    output logic                          o_flag
);

    localparam int RAY_W = $clog2(MAX_RAYS+1);
    localparam int CMP_W = (RAY_W > lsod_pkg::BOUND_W) ? RAY_W : lsod_pkg::BOUND_W;
    localparam int PRD_W = CMP_W + lsod_pkg::FRAC_W;

    logic [RAY_W-1:0] r_cnt, n_cnt;
    logic             r_flag, n_flag;

    logic [CMP_W-1:0] start_x, end_x, lo, hi, idx_x, max_x;
    logic             covered, in_sec;
    logic [RAY_W-1:0] cnt_upd;
    logic [PRD_W-1:0] lhs, rhs;

    always_comb begin
        max_x   = CMP_W'(MAX_RAYS);
        start_x = CMP_W'(i_start);
        end_x   = CMP_W'(i_end);
        idx_x   = CMP_W'(i_ray_idx);
        lo      = (start_x > max_x) ? max_x : start_x;
        hi      = (end_x > max_x) ? max_x : end_x;
        covered = (lo <= hi);
        in_sec  = i_ctl.hit && (lo <= idx_x) && (idx_x < hi);
        cnt_upd = r_cnt + RAY_W'(in_sec);
        // count * 256 against span * fraction
        lhs     = PRD_W'({cnt_upd, 8'd0});
        rhs     = PRD_W'(hi - lo) * PRD_W'(i_frac);
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_flag = r_flag;
        if (i_ctl.step) begin
            if (i_ctl.last) begin
                n_cnt = '0;
                if (covered) begin
                    n_flag = (lhs >= rhs);
                end
            end else begin
                n_cnt = cnt_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_flag <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_flag <= n_flag;
        end
    end

    assign o_flag = r_flag;

endmodule

[src/laser_sector_obstacle_detector.sv]
// Top level of the laser sector obstacle detector.
// Depends on lsod_pkg, lsod_if (lsod_in_if, lsod_out_if) and lsod_sector.
//
//  port      dir  kind        word
//  i_smp     in   valid/ready sample_range[15:0], sample_valid, scan_last
//  o_obs     out  valid/ready obstacle_right, obstacle_front, obstacle_left
//  i_cfg_*   in   write only  i_cfg_idx[2:0], i_cfg_data[15:0], i_cfg_we
//
// One sample word per cycle while no result stalls. A word is taken into the
// input register, and when it steps out it updates the ray index and the three
// sector counters. A word with scan_last loads the flags into the result
// register at the same edge it leaves the input register.
// Reset (synchronous, active low) clears ray index, counters, flags and the
// input and result valid bits; all sectors come up uncovered.
// A stalled result holds the pipe; if the input register is empty, one more word
// is still taken into it, then i_smp.ready drops until the result is taken.
module laser_sector_obstacle_detector #(
    parameter int MAX_RAYS = lsod_pkg::MAX_RAYS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lsod_in_if.sink                      i_smp,
    lsod_out_if.source                   o_obs,
    input  logic                         i_cfg_we,
    input  logic [lsod_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [lsod_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int RAY_W = $clog2(MAX_RAYS+1);

    // configuration registers
    logic [lsod_pkg::RANGE_W-1:0] r_near;
    logic [lsod_pkg::FRAC_W-1:0]  r_frac;
    logic [lsod_pkg::BOUND_W-1:0] r_start [lsod_pkg::NUM_SEC];
    logic [lsod_pkg::BOUND_W-1:0] r_end   [lsod_pkg::NUM_SEC];

    // input register
    logic                         r_in_vld, n_in_vld;
    logic [lsod_pkg::RANGE_W-1:0] r_range;
    logic                         r_svalid;
    logic                         r_last;

    // scan position and result register
    logic [RAY_W-1:0]             r_idx, n_idx;
    logic                         r_out_vld, n_out_vld;

    logic                         advance, in_acc, at_max;
    lsod_pkg::t_sec_ctl           ctl;
    logic [lsod_pkg::NUM_SEC-1:0] flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= lsod_pkg::NEAR_RST;
            r_frac <= lsod_pkg::FRAC_RST;
            for (int s = 0; s < lsod_pkg::NUM_SEC; s++) begin
                r_start[s] <= lsod_pkg::START_RST;
                r_end[s]   <= lsod_pkg::END_RST;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsod_pkg::REG_NEAR_THRESHOLD: r_near <= i_cfg_data[lsod_pkg::RANGE_W-1:0];
                lsod_pkg::REG_COUNT_FRACTION: r_frac <= i_cfg_data[lsod_pkg::FRAC_W-1:0];
                lsod_pkg::REG_RIGHT_START:
                    r_start[lsod_pkg::SEC_RIGHT] <= i_cfg_data[lsod_pkg::BOUND_W-1:0];
                lsod_pkg::REG_RIGHT_END:
                    r_end[lsod_pkg::SEC_RIGHT]   <= i_cfg_data[lsod_pkg::BOUND_W-1:0];
                lsod_pkg::REG_FRONT_START:
                    r_start[lsod_pkg::SEC_FRONT] <= i_cfg_data[lsod_pkg::BOUND_W-1:0];
                lsod_pkg::REG_FRONT_END:
                    r_end[lsod_pkg::SEC_FRONT]   <= i_cfg_data[lsod_pkg::BOUND_W-1:0];
                lsod_pkg::REG_LEFT_START:
                    r_start[lsod_pkg::SEC_LEFT]  <= i_cfg_data[lsod_pkg::BOUND_W-1:0];
                lsod_pkg::REG_LEFT_END:
                    r_end[lsod_pkg::SEC_LEFT]    <= i_cfg_data[lsod_pkg::BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    // pipe moves when the result slot is free or being emptied
    assign advance     = !r_out_vld || o_obs.ready;
    assign i_smp.ready = !r_in_vld || advance;
    assign in_acc      = i_smp.valid && i_smp.ready;
    assign at_max      = (r_idx == RAY_W'(MAX_RAYS));

    always_comb begin
        ctl.step = r_in_vld && advance;
        ctl.last = r_last;
        // rays past the end of the scan count nowhere
        ctl.hit  = r_svalid && (r_range <= r_near) && !at_max;
    end

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_acc) begin
            n_in_vld = 1'b1;
        end else if (ctl.step) begin
            n_in_vld = 1'b0;
        end

        n_idx = r_idx;
        if (ctl.step) begin
            if (r_last) begin
                n_idx = '0;
            end else if (!at_max) begin
                n_idx = r_idx + RAY_W'(1);
            end
        end

        n_out_vld = r_out_vld;
        if (ctl.step && r_last) begin
            n_out_vld = 1'b1;
        end else if (o_obs.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    // input payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_range  <= i_smp.sample_range;
            r_svalid <= i_smp.sample_valid;
            r_last   <= i_smp.scan_last;
        end
    end

    // flag registers inside the sectors double as the result payload;
    // they only change on a step, so they hold while the result stalls
    for (genvar s = 0; s < lsod_pkg::NUM_SEC; s++) begin : g_sec
        lsod_sector #(
            .MAX_RAYS (MAX_RAYS)
        ) u_sec (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_ray_idx (r_idx),
            .i_start   (r_start[s]),
            .i_end     (r_end[s]),
            .i_frac    (r_frac),
            .o_flag    (flags[s])
        );
    end

    assign o_obs.valid          = r_out_vld;
    assign o_obs.obstacle_right = flags[lsod_pkg::SEC_RIGHT];
    assign o_obs.obstacle_front = flags[lsod_pkg::SEC_FRONT];
    assign o_obs.obstacle_left  = flags[lsod_pkg::SEC_LEFT];

endmodule

[src/lsod_chk.sv]
// Port-level checker for the laser sector obstacle detector.
// Bound to laser_sector_obstacle_detector; no package dependency.
module lsod_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_flags
);

    // a result is offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before handshake");

    // flags do not move under a stalled result
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_flags))
        else $error("result flags changed while stalled");

    // a fresh result comes from an earlier accepted last-of-scan word
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
        else $error("result without a matching end of scan");

    // with the result slot empty the input never backs up
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result slot");

endmodule

bind laser_sector_obstacle_detector lsod_chk u_lsod_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_smp.valid),
    .in_ready  (i_smp.ready),
    .in_last   (i_smp.scan_last),
    .out_valid (o_obs.valid),
    .out_ready (o_obs.ready),
    .out_flags ({o_obs.obstacle_left, o_obs.obstacle_front, o_obs.obstacle_right})
);

[test/tb.sv]
// Testbench for laser_sector_obstacle_detector: random and directed scans,
// with a self-checking sector flag tracker.
// Depends on lsod_pkg, lsod_in_if / lsod_out_if and the detector RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsod_pkg::*;

    localparam int MAX_RAYS      = MAX_RAYS_DEF;
    localparam int NUM_REGS      = 2 ** IDX_W;
    localparam int RANDOM_ITEMS  = 1380;   // sample words in the random part
    localparam int LONG_PHASE    = 2;      // phase that runs one overlong scan
    localparam int HOLD_PHASE    = 1;      // phase with the long result hold-off
    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 6;      // pipe is two deep; margin on top
    localparam int DRAIN_GUARD   = 20000;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic right;
        logic front;
        logic left;
    } t_obs_flags;

    // Tracks the scan state and keeps the flag words still owed by the DUT.
    class t_sector_flag_tracker;
        logic [RANGE_W-1:0] near_thr;
        logic [FRAC_W-1:0]  frac;
        logic [BOUND_W-1:0] sec_lo [NUM_SEC];
        logic [BOUND_W-1:0] sec_hi [NUM_SEC];
        int                 ray_idx;
        int                 near_cnt [NUM_SEC];
        logic [NUM_SEC-1:0] flags;
        t_obs_flags         flags_due [$];
        int errors, samples, scans, hits, checked, settings;

        function new();
            near_thr = NEAR_RST;
            frac     = FRAC_RST;
            for (int s = 0; s < NUM_SEC; s++) begin
                sec_lo[s]   = START_RST;
                sec_hi[s]   = END_RST;
                near_cnt[s] = 0;
            end
            ray_idx  = 0;
            flags    = '0;
            errors   = 0;
            samples  = 0;
            scans    = 0;
            hits     = 0;
            checked  = 0;
            settings = 0;
        endfunction

        function int clip_bound(logic [BOUND_W-1:0] v);
            return (int'(v) > MAX_RAYS) ? MAX_RAYS : int'(v);
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_NEAR_THRESHOLD: near_thr = data[RANGE_W-1:0];
                REG_COUNT_FRACTION: frac = data[FRAC_W-1:0];
                REG_RIGHT_START:    sec_lo[SEC_RIGHT] = data[BOUND_W-1:0];
                REG_RIGHT_END:      sec_hi[SEC_RIGHT] = data[BOUND_W-1:0];
                REG_FRONT_START:    sec_lo[SEC_FRONT] = data[BOUND_W-1:0];
                REG_FRONT_END:      sec_hi[SEC_FRONT] = data[BOUND_W-1:0];
                REG_LEFT_START:     sec_lo[SEC_LEFT] = data[BOUND_W-1:0];
                REG_LEFT_END:       sec_hi[SEC_LEFT] = data[BOUND_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("tb: error @%0t: %s", $realtime, msg);
        endfunction

        // One accepted sample word.
        function void take_sample(logic [RANGE_W-1:0] rng, logic vld, logic lst);
            int         lo;
            int         hi;
            t_obs_flags due;
            samples++;
            if (vld && rng <= near_thr && ray_idx < MAX_RAYS) begin
                for (int s = 0; s < NUM_SEC; s++) begin
                    lo = clip_bound(sec_lo[s]);
                    hi = clip_bound(sec_hi[s]);
                    if (lo <= ray_idx && ray_idx < hi) begin
                        near_cnt[s]++;
                        hits++;
                    end
                end
            end
            if (!lst) begin
                if (ray_idx < MAX_RAYS)
                    ray_idx++;
                return;
            end
            // end of scan: covered sectors re-evaluate, uncovered ones keep their flag
            for (int s = 0; s < NUM_SEC; s++) begin
                lo = clip_bound(sec_lo[s]);
                hi = clip_bound(sec_hi[s]);
                if (lo <= hi)
                    flags[s] = (longint'(near_cnt[s]) * 256 >= longint'(hi - lo) * frac);
                near_cnt[s] = 0;
            end
            ray_idx   = 0;
            due.right = flags[SEC_RIGHT];
            due.front = flags[SEC_FRONT];
            due.left  = flags[SEC_LEFT];
            flags_due.insert(flags_due.size(), due);
            scans++;
        endfunction

        function void check_flags(t_obs_flags got);
            t_obs_flags want;
            if (flags_due.size() == 0) begin
                note_error($sformatf("flag word r%b f%b l%b with none due",
                                     got.right, got.front, got.left));
                return;
            end
            want = flags_due.pop_front();
            checked++;
            if (got.right !== want.right || got.front !== want.front ||
                got.left !== want.left)
                note_error($sformatf("scan %0d: want r%b f%b l%b, got r%b f%b l%b",
                                     checked, want.right, want.front, want.left,
                                     got.right, got.front, got.left));
        endfunction

        function void close_out();
            if (flags_due.size() != 0)
                note_error($sformatf("%0d flag words never came out", flags_due.size()));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    lsod_in_if  smp_if ();
    lsod_out_if obs_if ();

    t_sector_flag_tracker tracker;
    bit hold_req   = 1'b0;   // main flow asks the sink for one long hold-off
    int holds_done = 0;
    int smp_stalls = 0;      // cycles a word was offered and refused

    laser_sector_obstacle_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_if),
        .o_obs      (obs_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly none, otherwise from one of two ranges, the long one rarer.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one sample word after an optional idle gap and wait for the accept.
    // valid is only lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_word(input logic [RANGE_W-1:0] rng, input logic vld,
                             input logic lst, input int gap);
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid        <= 1'b1;
        smp_if.sample_range <= rng;
        smp_if.sample_valid <= vld;
        smp_if.scan_last    <= lst;
        @(posedge i_clk);
        while (!smp_if.ready) begin
            smp_stalls++;
            @(posedge i_clk);
        end
        tracker.take_sample(rng, vld, lst);
    endtask

    // Register write: the value lands at the next rising edge.
    // Caller drops i_cfg_we once the batch is done.
    task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    // Stop offering, wait for every owed flag word, then let the pipe empty out.
    // Words without scan_last leave nothing in the queue, hence the extra cycles.
    task automatic settle();
        int guard;
        smp_if.valid <= 1'b0;
        i_cfg_we     <= 1'b0;
        guard = 0;
        while (tracker.flags_due.size() > 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random bound: mostly inside the scan, sometimes exactly at or past MAX_RAYS.
    function automatic logic [CFG_W-1:0] rand_bound(int scale);
        logic [CFG_W-1:0] d;
        int               r;
        d = CFG_W'($urandom);   // junk above the register width must be dropped
        r = $urandom_range(0, 99);
        if (r < 80)
            d[BOUND_W-1:0] = BOUND_W'($urandom_range(0, scale + 2));
        else if (r < 88)
            d[BOUND_W-1:0] = BOUND_W'(MAX_RAYS);
        else if (r < 94)
            d[BOUND_W-1:0] = BOUND_W'($urandom_range(MAX_RAYS + 1, 2 ** BOUND_W - 1));
        else
            d[BOUND_W-1:0] = BOUND_W'($urandom_range(0, MAX_RAYS));
        return d;
    endfunction

    task automatic write_random_config(input int scale);
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] d;
        int               r;
        for (int k = 0; k < NUM_REGS; k++) begin
            idx = IDX_W'(k);
            if ($urandom_range(0, 99) < 85) begin
                r = $urandom_range(0, 9);
                case (idx)
                    REG_NEAR_THRESHOLD: begin
                        d = (r == 0) ? '0 : (r == 1) ? '1 : CFG_W'($urandom);
                    end
                    REG_COUNT_FRACTION: begin
                        d = CFG_W'($urandom);
                        d[FRAC_W-1:0] = (r == 0) ? '0 : (r == 1) ? '1 :
                                        (r == 2) ? FRAC_W'(1) : FRAC_W'($urandom);
                    end
                    default: d = rand_bound(scale);
                endcase
                set_reg(idx, d);
            end
        end
        i_cfg_we <= 1'b0;
        tracker.settings++;
    endtask

    // Range mix: some right around the threshold, some at the extremes.
    function automatic logic [RANGE_W-1:0] rand_range();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return tracker.near_thr + RANGE_W'($urandom_range(0, 2)) - RANGE_W'(1);
        if (r < 25)
            return '0;
        if (r < 30)
            return '1;
        return RANGE_W'($urandom);
    endfunction

    // Result sink: checks accepted flag words and throttles ready.
    initial begin : result_sink
        int         stall_left;
        int         hold_left;
        int         mode_left;
        bit         calm;
        t_obs_flags got;
        stall_left = 0;
        hold_left  = 0;
        mode_left  = 0;
        calm       = 1'b0;
        obs_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && obs_if.valid && obs_if.ready) begin
                got.right = obs_if.obstacle_right;
                got.front = obs_if.obstacle_front;
                got.left  = obs_if.obstacle_left;
                tracker.check_flags(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                // long hold-off: sender keeps pushing, the DUT must back up
                hold_left--;
                obs_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                obs_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    calm      = ($urandom_range(0, 3) == 0);   // stretch with no stalls
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                stall_left = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
                if (stall_left > 0) begin
                    stall_left--;
                    obs_if.ready <= 1'b0;
                end else begin
                    obs_if.ready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int               phase;
        int               short_items;
        int               scale;
        int               n_scans;
        int               n_words;
        bit               no_gap;
        bit               cut;
        logic [CFG_W-1:0] d;

        tracker = new();
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= REG_NEAR_THRESHOLD;
        i_cfg_data          <= '0;
        smp_if.valid        <= 1'b0;
        smp_if.sample_range <= '0;
        smp_if.sample_valid <= 1'b0;
        smp_if.scan_last    <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // Reset settings: every sector uncovered, flags stay at zero.
        send_word(RANGE_W'(0), 1'b1, 1'b0, 0);
        send_word('1, 1'b0, 1'b1, 0);
        settle();

        // Overlapping right/front, empty left, strictest fraction.
        set_reg(REG_NEAR_THRESHOLD, CFG_W'(1000));
        set_reg(REG_COUNT_FRACTION, CFG_W'(255));
        set_reg(REG_RIGHT_START, CFG_W'(0));
        set_reg(REG_RIGHT_END, CFG_W'(4));
        set_reg(REG_FRONT_START, CFG_W'(2));
        set_reg(REG_FRONT_END, CFG_W'(6));
        set_reg(REG_LEFT_START, CFG_W'(3));
        set_reg(REG_LEFT_END, CFG_W'(3));
        i_cfg_we <= 1'b0;
        tracker.settings++;
        send_word(RANGE_W'(0), 1'b1, 1'b0, 0);
        send_word(RANGE_W'(1000), 1'b1, 1'b0, 1);    // exactly at the threshold
        send_word(RANGE_W'(1001), 1'b1, 1'b0, 0);    // just above
        send_word(RANGE_W'(0), 1'b0, 1'b0, 2);       // no return: never counts
        send_word('1, 1'b0, 1'b0, 0);
        send_word(RANGE_W'(500), 1'b1, 1'b1, 0);
        settle();

        // Zero fraction, an uncovered right, front clamped to an empty sector at
        // the scan end, left spanning the whole scan.
        set_reg(REG_NEAR_THRESHOLD, '1);
        set_reg(REG_COUNT_FRACTION, CFG_W'(0));
        set_reg(REG_RIGHT_START, CFG_W'(5));
        set_reg(REG_RIGHT_END, CFG_W'(2));
        set_reg(REG_FRONT_START, CFG_W'(MAX_RAYS));
        set_reg(REG_FRONT_END, CFG_W'(2 ** BOUND_W - 1));
        set_reg(REG_LEFT_START, CFG_W'(0));
        set_reg(REG_LEFT_END, CFG_W'(MAX_RAYS));
        i_cfg_we <= 1'b0;
        tracker.settings++;
        send_word('1, 1'b1, 1'b0, 0);
        send_word('1, 1'b1, 1'b0, 0);
        send_word(RANGE_W'(12345), 1'b0, 1'b1, 1);
        settle();

        // Threshold zero, smallest nonzero fraction, left uncovered keeps its flag.
        set_reg(REG_NEAR_THRESHOLD, CFG_W'(0));
        set_reg(REG_COUNT_FRACTION, CFG_W'(1));
        set_reg(REG_RIGHT_START, CFG_W'(0));
        set_reg(REG_RIGHT_END, CFG_W'(3));
        set_reg(REG_LEFT_START, CFG_W'(1));
        set_reg(REG_LEFT_END, CFG_W'(0));
        i_cfg_we <= 1'b0;
        tracker.settings++;
        send_word(RANGE_W'(0), 1'b1, 1'b0, 0);
        send_word(RANGE_W'(1), 1'b1, 1'b0, 0);
        send_word(RANGE_W'(0), 1'b1, 1'b1, 0);
        settle();

        // ---- random part ----
        // Most phases: new settings, then a handful of scans sized to the sectors.
        short_items = 0;
        phase       = 0;
        while (short_items < RANDOM_ITEMS) begin
            if (phase == LONG_PHASE) begin
                // One scan past MAX_RAYS with sectors hugging the top of the scan;
                // the ray index must saturate and late rays count nowhere.
                set_reg(REG_NEAR_THRESHOLD, CFG_W'(40000));
                d = CFG_W'($urandom);
                set_reg(REG_COUNT_FRACTION, d);
                set_reg(REG_RIGHT_START, CFG_W'(MAX_RAYS - 24));
                set_reg(REG_RIGHT_END, CFG_W'(MAX_RAYS));
                set_reg(REG_FRONT_START, CFG_W'(MAX_RAYS - 14));
                set_reg(REG_FRONT_END, CFG_W'(1600));
                set_reg(REG_LEFT_START, CFG_W'(MAX_RAYS - 4));
                set_reg(REG_LEFT_END, CFG_W'(2 ** BOUND_W - 1));
                i_cfg_we <= 1'b0;
                tracker.settings++;
                n_words = MAX_RAYS + $urandom_range(6, 26);
                for (int w = 0; w < n_words; w++) begin
                    send_word(RANGE_W'($urandom), ($urandom_range(0, 9) != 0),
                              (w == n_words - 1), ($urandom_range(0, 3) == 0) ? pick_gap() : 0);
                    short_items++;
                end
            end else begin
                scale = (phase == HOLD_PHASE) ? $urandom_range(1, 3) : $urandom_range(1, 40);
                write_random_config(scale);
                no_gap  = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
                n_scans = (phase == HOLD_PHASE) ? 12 : $urandom_range(2, 8);
                if (phase == HOLD_PHASE)
                    hold_req = 1'b1;
                for (int s = 0; s < n_scans; s++) begin
                    // mostly scans that fit the sectors, a few noisy long ones
                    n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3 * scale + 5)
                                                          : $urandom_range(1, scale + 3);
                    // now and then the last scan stays open across the next settings
                    cut = (s == n_scans - 1) && ($urandom_range(0, 9) == 0);
                    for (int w = 0; w < n_words; w++) begin
                        send_word(rand_range(), ($urandom_range(0, 99) < 85),
                                  (w == n_words - 1) && !cut, no_gap ? 0 : pick_gap());
                        short_items++;
                    end
                end
            end
            settle();
            phase++;
        end

        tracker.close_out();
        $display("tb: %0d sample words, %0d scans checked over %0d settings, %0d sector hits",
                 tracker.samples, tracker.checked, tracker.settings, tracker.hits);
        $display("tb: %0d long hold-offs, input refused for %0d cycles, %0d errors",
                 holds_done, smp_stalls, tracker.errors);
        if (tracker.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
